// ----- design/qla_pkg.sv -----
// shared types, constants and helper functions for the quadrature lock-in accumulator
`default_nettype none
package qla_pkg;

    // field widths
    localparam int SAMPLE_BITS     = 12;
    localparam int ADDR_BITS       = 10;
    localparam int VALUE_BITS      = 16;
    localparam int PHASE_BITS      = 11;
    localparam int SUM_BITS        = 48;
    localparam int MODE_BITS       = 2;
    localparam int PROD_BITS       = SAMPLE_BITS + 1 + VALUE_BITS;

    // parameter defaults
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int ACC_BITS_DEF    = 48;

    // table words at or above this address are never stored
    localparam int REGION_LIMIT    = 584;

    // stream packing
    localparam int IN_ADDR_LSB     = 0;
    localparam int IN_VALUE_LSB    = IN_ADDR_LSB + ADDR_BITS;
    localparam int IN_SAMPLE_LSB   = IN_VALUE_LSB + VALUE_BITS;
    localparam int IN_USED_BITS    = IN_SAMPLE_LSB + SAMPLE_BITS;
    localparam int IN_TDATA_BITS   = ((IN_USED_BITS + 7) / 8) * 8;
    localparam int OUT_USED_BITS   = 2 * SUM_BITS + SAMPLE_BITS;
    localparam int OUT_TDATA_BITS  = ((OUT_USED_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS    = OUT_TDATA_BITS - OUT_USED_BITS;

    // request kinds carried on tuser
    localparam logic REQ_TABLE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // frequency modes
    localparam logic [MODE_BITS-1:0] MODE_WIDE   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_MID    = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_NARROW = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_DIFF   = 2'd3;
    localparam logic [MODE_BITS-1:0] MODE_RESET  = MODE_MID;

    // quadrants
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic                   mode_diff;
        logic [1:0]             quad;
        logic                   last;
        logic [SAMPLE_BITS-1:0] sample;
    } t_meta;

    typedef struct packed {
        logic load;
        logic fire;
    } t_s2_ctl;

    typedef struct packed {
        logic valid;
        logic last;
    } t_s2_stat;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]   amplitude;
        logic signed [SUM_BITS-1:0] imag_sum;
        logic signed [SUM_BITS-1:0] real_sum;
    } t_result;

    function automatic logic [ADDR_BITS-1:0] region_base(input logic [MODE_BITS-1:0] mode);
        logic [ADDR_BITS-1:0] base;
        unique case (mode)
            MODE_WIDE:   base = 10'd0;
            MODE_MID:    base = 10'd512;
            MODE_NARROW: base = 10'd576;
            default:     base = 10'd0;
        endcase
        return base;
    endfunction

    // region length minus one
    function automatic logic [ADDR_BITS-1:0] region_mask(input logic [MODE_BITS-1:0] mode);
        logic [ADDR_BITS-1:0] mask;
        unique case (mode)
            MODE_WIDE:   mask = 10'd511;
            MODE_MID:    mask = 10'd63;
            MODE_NARROW: mask = 10'd7;
            default:     mask = 10'd3;
        endcase
        return mask;
    endfunction

    function automatic logic [1:0] region_quad(input logic [PHASE_BITS-1:0] phase,
                                               input logic [MODE_BITS-1:0] mode);
        logic [1:0] q;
        unique case (mode)
            MODE_WIDE:   q = phase[10:9];
            MODE_MID:    q = phase[7:6];
            MODE_NARROW: q = phase[4:3];
            default:     q = phase[1:0];
        endcase
        return q;
    endfunction

endpackage
`default_nettype wire

// ----- design/quadrature_lockin_accumulator_top.sv -----
// top level of the quadrature lock-in accumulator
//
// input stream s_axis: tuser selects the beat kind (table word or adc sample),
// tdata carries table address, table value and sample, tlast ends a record.
// a table beat writes one word of the quarter-wave sine table (regions of
// 512, 64 and 8 words at 0, 512, 576); writes at 584 and above are dropped.
// a sample beat reads the two mirrored table words, multiplies both by the
// sample and folds the products into the real and imag sums by quadrant.
// i_cfg_we / i_cfg_data load the frequency mode; mode 3 skips the table.
// output stream m_axis: one beat per record, sent for the sample with tlast.
// path: table read into stage 1, multiply into stage 2, then the accumulate
// lands straight in the output register that drives the result beat.
// throughput: one beat per cycle while the pipeline is not backed up, set by
// the registered table read and the one accumulate step per cycle.
// reset: mode returns to 1, sums, phase and min/max clear; table contents
// are kept undefined until written.
// a stalled receiver holds the result in the output register; samples keep
// flowing until the next record's last sample waits in stage 2 and stage 1
// fills behind it, then s_axis_tready drops.
`default_nettype none
module quadrature_lockin_accumulator_top #(
    parameter int TABLE_DEPTH = qla_pkg::TABLE_DEPTH_DEF,
    parameter int ACC_BITS    = qla_pkg::ACC_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [qla_pkg::MODE_BITS-1:0]       i_cfg_data,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // table_address, table_value, sample (low bit up), zero pad
    input  wire  [qla_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
    // req_type
    input  wire                                 s_axis_tuser,
    // last_sample
    input  wire                                 s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // real_sum, imag_sum, amplitude (low bit up), zero pad
    output logic [qla_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata
);
    import qla_pkg::*;

    logic [MODE_BITS-1:0]       r_mode;
    logic [PHASE_BITS-1:0]      r_phase;
    logic                       r_s1_valid;
    t_meta                      r_s1_meta;
    logic                       r_o_valid;
    t_result                    r_out;

    logic [ADDR_BITS-1:0]       w_addr;
    logic [VALUE_BITS-1:0]      w_value;
    logic [SAMPLE_BITS-1:0]     w_sample;
    logic                       w_accept;
    logic                       w_is_sample;
    logic                       w_take_sample;
    logic                       w_table_we;
    logic [ADDR_BITS-1:0]       w_base;
    logic [ADDR_BITS-1:0]       w_mask;
    logic [ADDR_BITS-1:0]       w_j;
    logic [ADDR_BITS-1:0]       w_raddr_a;
    logic [ADDR_BITS-1:0]       w_raddr_b;
    logic signed [VALUE_BITS-1:0] w_rdata_a;
    logic signed [VALUE_BITS-1:0] w_rdata_b;

    logic                       w_out_free;
    logic                       w_s2_fire;
    logic                       w_s2_ready;
    logic                       w_s1_ready;
    t_s2_ctl                    w_ctl;
    t_s2_stat                   w_stat;
    t_result                    w_result;

    // unpack the input beat
    assign w_addr   = s_axis_tdata[IN_ADDR_LSB +: ADDR_BITS];
    assign w_value  = s_axis_tdata[IN_VALUE_LSB +: VALUE_BITS];
    assign w_sample = s_axis_tdata[IN_SAMPLE_LSB +: SAMPLE_BITS];

    // pipeline flow: stage 2 only waits on the output register for a last sample
    assign w_out_free = !r_o_valid || m_axis_tready;
    assign w_s2_fire  = w_stat.valid && (!w_stat.last || w_out_free);
    assign w_s2_ready = !w_stat.valid || w_s2_fire;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign w_ctl.load = r_s1_valid && w_s2_ready;
    assign w_ctl.fire = w_s2_fire;

    assign s_axis_tready = w_s1_ready;
    assign w_accept      = s_axis_tvalid && w_s1_ready;
    assign w_is_sample   = (s_axis_tuser == REQ_SAMPLE);
    assign w_take_sample = w_accept && w_is_sample;
    assign w_table_we    = w_accept && (s_axis_tuser == REQ_TABLE)
                           && (32'(w_addr) < REGION_LIMIT)
                           && (32'(w_addr) < TABLE_DEPTH);

    // mirrored table addresses j and L-1-j inside the active region
    assign w_base    = region_base(r_mode);
    assign w_mask    = region_mask(r_mode);
    assign w_j       = ADDR_BITS'(r_phase) & w_mask;
    assign w_raddr_a = w_base + w_j;
    assign w_raddr_b = w_base + (w_mask & ~w_j);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    // phase advances per sample and restarts with each record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_take_sample) begin
            r_phase <= s_axis_tlast ? '0 : r_phase + 1'b1;
        end
    end

    // stage 1 sits beside the registered table read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= w_take_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_sample) begin
            r_s1_meta.mode_diff <= (r_mode == MODE_DIFF);
            r_s1_meta.quad      <= region_quad(r_phase, r_mode);
            r_s1_meta.last      <= s_axis_tlast;
            r_s1_meta.sample    <= w_sample;
        end
    end

    qla_table #(
        .DEPTH      (TABLE_DEPTH)
    ) u_table (
        .i_clk      (i_clk),
        .i_we       (w_table_we),
        .i_waddr    (w_addr),
        .i_wdata    (w_value),
        .i_re       (w_take_sample),
        .i_raddr_a  (w_raddr_a),
        .i_raddr_b  (w_raddr_b),
        .o_rdata_a  (w_rdata_a),
        .o_rdata_b  (w_rdata_b)
    );

    qla_accum #(
        .ACC_BITS   (ACC_BITS)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_meta     (r_s1_meta),
        .i_rdata_a  (w_rdata_a),
        .i_rdata_b  (w_rdata_b),
        .o_stat     (w_stat),
        .o_result   (w_result)
    );

    // output register, loaded when the last sample of a record accumulates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_s2_fire && w_stat.last) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_fire && w_stat.last) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {OUT_PAD_BITS'(0), r_out.amplitude, r_out.imag_sum,
                            r_out.real_sum};

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !m_axis_tvalid))
        else $error("pipeline not empty after reset");

    a_phase_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take_sample && s_axis_tlast) |=> (r_phase == '0))
        else $error("phase did not restart after last sample");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_fire && w_stat.last) |=> m_axis_tvalid)
        else $error("result of a record was not presented");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_s1_valid && w_stat.valid && r_o_valid))
        else $error("input stalled with room in the pipeline");
`endif

endmodule
`default_nettype wire

// ----- design/qla_table.sv -----
// sine table memory, one write port and two registered read ports
`default_nettype none
module qla_table #(
    parameter int DEPTH = qla_pkg::TABLE_DEPTH_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_we,
    input  wire  [qla_pkg::ADDR_BITS-1:0]           i_waddr,
    input  wire  [qla_pkg::VALUE_BITS-1:0]          i_wdata,
    input  wire                                     i_re,
    input  wire  [qla_pkg::ADDR_BITS-1:0]           i_raddr_a,
    input  wire  [qla_pkg::ADDR_BITS-1:0]           i_raddr_b,
    output logic signed [qla_pkg::VALUE_BITS-1:0]   o_rdata_a,
    output logic signed [qla_pkg::VALUE_BITS-1:0]   o_rdata_b
);
    import qla_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic signed [VALUE_BITS-1:0] r_rdata_a;
    logic signed [VALUE_BITS-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[AW'(i_waddr)] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= mem[AW'(i_raddr_a)];
            r_rdata_b <= mem[AW'(i_raddr_b)];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
`default_nettype wire

// ----- design/qla_accum.sv -----
// product stage and accumulate stage with running min and max
`default_nettype none
module qla_accum #(
    parameter int ACC_BITS = qla_pkg::ACC_BITS_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  qla_pkg::t_s2_ctl                        i_ctl,
    input  qla_pkg::t_meta                          i_meta,
    input  wire signed [qla_pkg::VALUE_BITS-1:0]    i_rdata_a,
    input  wire signed [qla_pkg::VALUE_BITS-1:0]    i_rdata_b,
    output qla_pkg::t_s2_stat                       o_stat,
    output qla_pkg::t_result                        o_result
);
    import qla_pkg::*;

    logic signed [SAMPLE_BITS:0]    w_samp_s;
    logic signed [PROD_BITS-1:0]    w_prod_a;
    logic signed [PROD_BITS-1:0]    w_prod_b;

    logic                           r_s2_valid;
    logic                           r_s2_last;
    logic [1:0]                     r_s2_quad;
    logic [SAMPLE_BITS-1:0]         r_s2_sample;
    logic signed [PROD_BITS-1:0]    r_s2_pa;
    logic signed [PROD_BITS-1:0]    r_s2_pb;

    logic signed [ACC_BITS-1:0]     r_real;
    logic signed [ACC_BITS-1:0]     r_imag;
    logic [SAMPLE_BITS-1:0]         r_min;
    logic [SAMPLE_BITS-1:0]         r_max;

    logic signed [ACC_BITS-1:0]     w_ea;
    logic signed [ACC_BITS-1:0]     w_eb;
    logic signed [ACC_BITS-1:0]     w_dr;
    logic signed [ACC_BITS-1:0]     w_di;
    logic signed [ACC_BITS-1:0]     n_real;
    logic signed [ACC_BITS-1:0]     n_imag;
    logic [SAMPLE_BITS-1:0]         n_min;
    logic [SAMPLE_BITS-1:0]         n_max;

    assign w_samp_s = $signed({1'b0, i_meta.sample});
    assign w_prod_a = PROD_BITS'(w_samp_s) * PROD_BITS'(i_rdata_a);
    assign w_prod_b = PROD_BITS'(w_samp_s) * PROD_BITS'(i_rdata_b);

    // stage 2: products; difference mode routes the sample through the b slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_ctl.fire || !r_s2_valid) begin
            r_s2_valid <= i_ctl.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_s2_last   <= i_meta.last;
            r_s2_quad   <= i_meta.quad;
            r_s2_sample <= i_meta.sample;
            if (i_meta.mode_diff) begin
                r_s2_pa <= '0;
                r_s2_pb <= PROD_BITS'(i_meta.sample);
            end else begin
                r_s2_pa <= w_prod_a;
                r_s2_pb <= w_prod_b;
            end
        end
    end

    assign w_ea = ACC_BITS'(r_s2_pa);
    assign w_eb = ACC_BITS'(r_s2_pb);

    always_comb begin
        case (r_s2_quad)
            QUAD_0: begin
                w_dr = w_ea;
                w_di = w_eb;
            end
            QUAD_1: begin
                w_dr = w_eb;
                w_di = -w_ea;
            end
            QUAD_2: begin
                w_dr = -w_ea;
                w_di = -w_eb;
            end
            default: begin
                w_dr = -w_eb;
                w_di = w_ea;
            end
        endcase
    end

    assign n_real = r_real + w_dr;
    assign n_imag = r_imag + w_di;
    assign n_max  = (r_s2_sample > r_max) ? r_s2_sample : r_max;
    assign n_min  = (r_s2_sample < r_min) ? r_s2_sample : r_min;

    // accumulate as the item leaves stage 2; the record clears after its last sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_real <= '0;
            r_imag <= '0;
            r_min  <= '1;
            r_max  <= '0;
        end else if (i_ctl.fire) begin
            if (r_s2_last) begin
                r_real <= '0;
                r_imag <= '0;
                r_min  <= '1;
                r_max  <= '0;
            end else begin
                r_real <= n_real;
                r_imag <= n_imag;
                r_min  <= n_min;
                r_max  <= n_max;
            end
        end
    end

    assign o_stat.valid       = r_s2_valid;
    assign o_stat.last        = r_s2_last;
    assign o_result.real_sum  = SUM_BITS'(n_real);
    assign o_result.imag_sum  = SUM_BITS'(n_imag);
    assign o_result.amplitude = n_max - n_min;

endmodule
`default_nettype wire

// ----- verif/quadrature_lockin_accumulator_top_tb.sv -----
// self-checking stream testbench for the quadrature lock-in accumulator
`timescale 1ns / 1ps
module quadrature_lockin_accumulator_top_tb;
    import qla_pkg::*;

    // quiet cycles after the last input beat before the pipeline counts as idle
    localparam int SETTLE_CYCLES = 8;
    // long receiver hold-off used to back the pipeline up
    localparam int HOLD_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 400000;

    // output field positions inside m_axis_tdata
    localparam int RE_LSB  = 0;
    localparam int IM_LSB  = SUM_BITS;
    localparam int AMP_LSB = 2 * SUM_BITS;

    typedef enum logic [2:0] {
        STEP_BEAT,   // one input beat
        STEP_MODE,   // drain, then load the frequency mode
        STEP_DRAIN,  // sender pauses until every result is back
        STEP_HOLD,   // ask the receiver for a long hold-off
        STEP_PACE    // switch the idling profile
    } t_step_kind;

    // idling profiles: who stalls how often
    typedef enum logic [1:0] {
        PACE_RX_SLOW,  // sender idles 32 percent, receiver 75
        PACE_TX_SLOW,  // sender idles 75 percent, receiver 32
        PACE_FREE      // no idling
    } t_pace;

    typedef struct {
        t_step_kind                    kind;
        logic                          user;
        logic                          last;
        logic [ADDR_BITS-1:0]          addr;
        logic signed [VALUE_BITS-1:0]  value;
        logic [SAMPLE_BITS-1:0]        sample;
        int                            arg;
    } t_plan_step;

    typedef struct {
        logic [SUM_BITS-1:0]    re;
        logic [SUM_BITS-1:0]    im;
        logic [SAMPLE_BITS-1:0] amp;
    } t_lockin_result;

    // clock, reset and block inputs, all known from time zero
    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_we      = 1'b0;
    logic [MODE_BITS-1:0]      i_cfg_data    = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // table_address, table_value, sample from the low bit up, zero pad
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
    // req_type
    logic                      s_axis_tuser  = 1'b0;
    // last_sample
    logic                      s_axis_tlast  = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // real_sum, imag_sum, amplitude from the low bit up, zero pad
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    // stimulus plan and the results still owed by the block
    t_plan_step      beat_plan[$];
    t_plan_step      offered;
    t_lockin_result  due_results[$];

    // predictor copy of the block state, at reset values
    logic signed [VALUE_BITS-1:0] sine_copy [0:1023];
    logic [PHASE_BITS-1:0]        phase_pos = '0;
    logic [SUM_BITS-1:0]          real_acc  = '0;
    logic [SUM_BITS-1:0]          imag_acc  = '0;
    logic [SAMPLE_BITS-1:0]       peak_lo   = '1;
    logic [SAMPLE_BITS-1:0]       peak_hi   = '0;
    logic [MODE_BITS-1:0]         mode_copy = MODE_RESET;

    // bookkeeping shared between the driver, the receiver and the main flow
    t_pace pace            = PACE_FREE;
    int    quiet_cycles    = 0;
    int    hold_requests   = 0;
    int    holds_served    = 0;
    int    hold_left       = 0;
    int    cycle_count     = 0;
    int    mismatches      = 0;
    int    records_checked = 0;
    int    table_beats     = 0;
    int    sample_beats    = 0;
    int    mode_writes     = 0;
    bit    stim_done       = 1'b0;

    quadrature_lockin_accumulator_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // idle chance in percent for one side under a profile
    function automatic int gap_pct(input t_pace p, input bit sender);
        case (p)
            PACE_RX_SLOW: return sender ? 32 : 75;
            PACE_TX_SLOW: return sender ? 75 : 32;
            default:      return 0;
        endcase
    endfunction

    // fold one accepted beat into the predicted state; a last sample yields a result
    task automatic fold_beat(input t_plan_step st);
        logic signed [SUM_BITS-1:0] smp;
        logic signed [SUM_BITS-1:0] d_re;
        logic signed [SUM_BITS-1:0] d_im;
        logic signed [SUM_BITS-1:0] p_a;
        logic signed [SUM_BITS-1:0] p_b;
        longint                     prod_a;
        longint                     prod_b;
        int                         base;
        int                         span_log;
        int                         span;
        int                         offs;
        logic [1:0]                 quad;
        t_lockin_result             res;
        if (st.user == REQ_TABLE) begin
            table_beats++;
            // writes at the region limit and above are dropped, tlast is ignored
            if (int'(st.addr) < REGION_LIMIT) sine_copy[st.addr] = st.value;
            return;
        end
        sample_beats++;
        if (st.sample > peak_hi) peak_hi = st.sample;
        if (st.sample < peak_lo) peak_lo = st.sample;
        smp  = {{(SUM_BITS-SAMPLE_BITS){1'b0}}, st.sample};
        d_re = '0;
        d_im = '0;
        if (mode_copy == MODE_DIFF) begin
            // four-phase difference, no table
            case (phase_pos[1:0])
                QUAD_0:  d_im = smp;
                QUAD_1:  d_re = smp;
                QUAD_2:  d_im = -smp;
                default: d_re = -smp;
            endcase
        end else begin
            case (mode_copy)
                MODE_WIDE: begin base = 0;   span_log = 9; end
                MODE_MID:  begin base = 512; span_log = 6; end
                default:   begin base = 576; span_log = 3; end
            endcase
            span   = 1 << span_log;
            offs   = int'(phase_pos) & (span - 1);
            quad   = 2'(phase_pos >> span_log);
            prod_a = longint'(st.sample) * longint'(sine_copy[base + offs]);
            prod_b = longint'(st.sample) * longint'(sine_copy[base + span - 1 - offs]);
            p_a    = prod_a[SUM_BITS-1:0];
            p_b    = prod_b[SUM_BITS-1:0];
            case (quad)
                QUAD_0:  begin d_re = p_a;  d_im = p_b;  end
                QUAD_1:  begin d_re = p_b;  d_im = -p_a; end
                QUAD_2:  begin d_re = -p_a; d_im = -p_b; end
                default: begin d_re = -p_b; d_im = p_a;  end
            endcase
        end
        real_acc  = real_acc + d_re;
        imag_acc  = imag_acc + d_im;
        phase_pos = phase_pos + 1'b1;
        if (st.last) begin
            res.re  = real_acc;
            res.im  = imag_acc;
            res.amp = peak_hi - peak_lo;
            due_results.push_back(res);
            // record state clears, table and mode stay
            phase_pos = '0;
            real_acc  = '0;
            imag_acc  = '0;
            peak_lo   = '1;
            peak_hi   = '0;
        end
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // plan building helpers
    task automatic plan_beat(input logic user, input logic last, input int addr,
                             input int value, input int smp);
        t_plan_step st;
        st.kind   = STEP_BEAT;
        st.user   = user;
        st.last   = last;
        st.addr   = ADDR_BITS'(addr);
        st.value  = VALUE_BITS'(value);
        st.sample = SAMPLE_BITS'(smp);
        st.arg    = 0;
        beat_plan.push_back(st);
    endtask

    // unused fields of a beat carry random bits
    task automatic plan_table(input int addr, input int value, input logic last);
        plan_beat(REQ_TABLE, last, addr, value, $urandom_range(4095));
    endtask

    task automatic plan_sample(input int smp, input logic last);
        plan_beat(REQ_SAMPLE, last, $urandom_range(1023), $urandom_range(65535), smp);
    endtask

    task automatic plan_ctl(input t_step_kind kind, input int arg);
        t_plan_step st;
        st.kind   = kind;
        st.user   = REQ_TABLE;
        st.last   = 1'b0;
        st.addr   = '0;
        st.value  = '0;
        st.sample = '0;
        st.arg    = arg;
        beat_plan.push_back(st);
    endtask

    // a run of random samples, closed by tlast or left open
    task automatic plan_record(input int len, input bit closed);
        int n;
        int smp;
        for (n = 0; n < len; n++) begin
            if ($urandom_range(9) == 0) smp = $urandom_range(1) ? 4095 : 0;
            else smp = $urandom_range(4095);
            plan_sample(smp, closed && (n == len - 1));
        end
    endtask

    // driver: feeds the input stream from the plan and predicts every accepted beat
    always @(posedge i_clk) begin : driver
        t_plan_step              st;
        logic                    nxt_valid;
        logic                    nxt_user;
        logic                    nxt_last;
        logic                    nxt_we;
        logic [MODE_BITS-1:0]    nxt_mode;
        logic [IN_TDATA_BITS-1:0] nxt_data;
        nxt_valid = s_axis_tvalid;
        nxt_user  = s_axis_tuser;
        nxt_last  = s_axis_tlast;
        nxt_data  = s_axis_tdata;
        nxt_mode  = i_cfg_data;
        nxt_we    = 1'b0;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            quiet_cycles++;
            // beat taken at this edge
            if (s_axis_tvalid && s_axis_tready) begin
                fold_beat(offered);
                quiet_cycles = 0;
                nxt_valid    = 1'b0;
            end
            if (!nxt_valid && beat_plan.size() != 0) begin
                st = beat_plan[0];
                case (st.kind)
                    STEP_BEAT: begin
                        // an offered beat is held until taken, gaps only come before it
                        if ($urandom_range(99) >= gap_pct(pace, 1'b1)) begin
                            offered   = st;
                            void'(beat_plan.pop_front());
                            nxt_valid = 1'b1;
                            nxt_user  = st.user;
                            nxt_last  = st.last;
                            nxt_data  = '0;
                            nxt_data[IN_ADDR_LSB +: ADDR_BITS]     = st.addr;
                            nxt_data[IN_VALUE_LSB +: VALUE_BITS]   = st.value;
                            nxt_data[IN_SAMPLE_LSB +: SAMPLE_BITS] = st.sample;
                        end
                    end
                    STEP_MODE, STEP_DRAIN: begin
                        // only touch the register with nothing owed and the pipeline empty
                        if (due_results.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                            if (st.kind == STEP_MODE) begin
                                nxt_we    = 1'b1;
                                nxt_mode  = MODE_BITS'(st.arg);
                                mode_copy = MODE_BITS'(st.arg);
                                mode_writes++;
                            end
                            void'(beat_plan.pop_front());
                        end
                    end
                    STEP_HOLD: begin
                        hold_requests++;
                        void'(beat_plan.pop_front());
                    end
                    default: begin
                        pace = t_pace'(st.arg);
                        void'(beat_plan.pop_front());
                    end
                endcase
            end
            stim_done = !nxt_valid && (beat_plan.size() == 0);
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tuser  <= nxt_user;
        s_axis_tlast  <= nxt_last;
        s_axis_tdata  <= nxt_data;
        i_cfg_we      <= nxt_we;
        i_cfg_data    <= nxt_mode;
    end

    // receiver: checks each result beat against the oldest prediction
    always @(posedge i_clk) begin : receiver
        t_lockin_result want;
        logic           nxt_ready;
        if (!i_rst_n) begin
            nxt_ready = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected result beat, expected none, got %0h",
                             $time, m_axis_tdata);
                end else begin
                    want = due_results.pop_front();
                    records_checked++;
                    check_field("real_sum", want.re, m_axis_tdata[RE_LSB +: SUM_BITS]);
                    check_field("imag_sum", want.im, m_axis_tdata[IM_LSB +: SUM_BITS]);
                    check_field("amplitude", want.amp,
                                m_axis_tdata[AMP_LSB +: SAMPLE_BITS]);
                    check_field("pad", '0, m_axis_tdata[OUT_TDATA_BITS-1:OUT_USED_BITS]);
                end
            end
            // long hold-off counted here, random stalls otherwise
            if (hold_left > 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = ($urandom_range(99) >= gap_pct(pace, 1'b0));
            end
        end
        m_axis_tready <= nxt_ready;
    end

    // plan, reset, wait for the end, report
    initial begin : main_flow
        int n;
        int pc;
        int r;
        int len;
        int smps;
        int recs;

        // fill every region word so no read ever sees an unwritten entry
        for (n = 0; n < REGION_LIMIT; n++) plan_table(n, $urandom_range(65535), 1'b0);

        // four-phase mode: a full group plus one, a partial group, a flat record
        plan_ctl(STEP_MODE, MODE_DIFF);
        plan_sample(4095, 1'b0);
        plan_sample(0, 1'b0);
        plan_sample(4095, 1'b0);
        plan_sample(0, 1'b0);
        plan_sample(4095, 1'b1);
        plan_sample(100, 1'b0);
        plan_sample(200, 1'b0);
        plan_sample(300, 1'b1);
        plan_sample(0, 1'b1);
        // table extremes, tlast on a table beat, dropped out-of-range writes
        plan_ctl(STEP_MODE, MODE_WIDE);
        plan_table(0, -32768, 1'b1);
        plan_table(511, 32767, 1'b0);
        plan_table(REGION_LIMIT, 32767, 1'b0);
        plan_table(1023, -32768, 1'b1);
        plan_sample(4095, 1'b1);
        // mode change in the middle of a record
        plan_sample(4095, 1'b0);
        plan_sample(0, 1'b0);
        plan_ctl(STEP_MODE, MODE_NARROW);
        plan_sample(2048, 1'b0);
        plan_sample(4095, 1'b1);
        plan_ctl(STEP_MODE, MODE_MID);
        plan_sample(1, 1'b0);
        plan_sample(4094, 1'b1);

        // random part under each idling profile
        for (pc = 0; pc < 3; pc++) begin
            plan_ctl(STEP_PACE, pc);
            if (t_pace'(pc) == PACE_FREE) begin
                // sender waits for all results, then the receiver backs the block up
                plan_ctl(STEP_DRAIN, 0);
                plan_ctl(STEP_HOLD, 0);
                for (n = 0; n < 8; n++) plan_record(1, 1'b1);
                // narrow-mode record through all four quadrants and past them
                plan_ctl(STEP_MODE, MODE_NARROW);
                plan_record(33, 1'b1);
            end
            smps = 0;
            recs = 0;
            while (smps < 24 || recs < 3) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    plan_ctl(STEP_MODE, $urandom_range(3));
                end else if (r < 16) begin
                    // rewrites of live words and dropped high addresses
                    plan_table($urandom_range(1023), $urandom_range(65535),
                               1'($urandom_range(1)));
                end else if (r < 20) begin
                    // open record carried across a mode change
                    len = $urandom_range(12, 1);
                    plan_record(len, 1'b0);
                    plan_ctl(STEP_MODE, $urandom_range(3));
                    smps += len;
                end else begin
                    r = $urandom_range(9);
                    if (r < 7) len = $urandom_range(8, 1);
                    else len = $urandom_range(32, 9);
                    plan_record(len, 1'b1);
                    smps += len;
                    recs++;
                end
            end
        end
        plan_record(3, 1'b1);

        // synchronous reset, once
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(stim_done && due_results.size() == 0) && cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);

        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, due_results.size());
            $display("Testbench completed WITH ERRORS");
        end else begin
            // tail: catch any stray result beat
            repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
            if (due_results.size() != 0) begin
                mismatches++;
                $display("%0t ns: %0d results expected but never seen",
                         $time, due_results.size());
            end
            $display("covered %0d table beats and %0d sample beats over %0d mode loads",
                     table_beats, sample_beats, mode_writes);
            $display("%0d records checked with gaps on both sides and a long output stall",
                     records_checked);
            if (mismatches == 0) begin
                $display("Testbench completed without errors");
            end else begin
                $display("Testbench completed WITH ERRORS");
            end
        end
        $finish;
    end

endmodule

// ----- quadrature_lockin_accumulator_top.f -----
design/qla_pkg.sv
design/qla_table.sv
design/qla_accum.sv
design/quadrature_lockin_accumulator_top.sv
verif/quadrature_lockin_accumulator_top_tb.sv
